@@ src/cmf_pkg.sv @@
// Package for the complex multipath FIR core: widths, register codes, shared types.
`default_nettype none
package cmf_pkg;

  localparam int TAP_W        = 16;
  localparam int FRAC_W       = 14;
  localparam int NUM_REGS     = 6;
  localparam int IDX_W        = 3;
  localparam int NUM_TAP_SETS = 3;
  localparam int MAX_TAPS     = 4;
  localparam int DEF_NUM_TAPS = 3;
  localparam int DEF_SAMPLE_W = 16;

  localparam logic [IDX_W-1:0] REG_TAP0_RE = 3'd0;
  localparam logic [IDX_W-1:0] REG_TAP0_IM = 3'd1;
  localparam logic [IDX_W-1:0] REG_TAP1_RE = 3'd2;
  localparam logic [IDX_W-1:0] REG_TAP1_IM = 3'd3;
  localparam logic [IDX_W-1:0] REG_TAP2_RE = 3'd4;
  localparam logic [IDX_W-1:0] REG_TAP2_IM = 3'd5;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [TAP_W-1:0]  data;
  } cfg_t;

  typedef struct packed {
    logic adv;
    logic load;
    logic clr;
    logic v1;
    logic v2;
  } ctl_t;

  function automatic logic signed [TAP_W-1:0] tap_reset(input logic [IDX_W-1:0] idx);
    logic signed [TAP_W-1:0] val;
    unique case (idx)
      REG_TAP0_RE: val = 16'sd13107;
      REG_TAP0_IM: val = 16'sd0;
      REG_TAP1_RE: val = 16'sd6554;
      REG_TAP1_IM: val = 16'sd3277;
      REG_TAP2_RE: val = 16'sd3277;
      REG_TAP2_IM: val = -16'sd1638;
      default:     val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

@@ src/cmf_cell.sv @@
// One FIR cell: delay register, complex tap, four products and the complex term.
`default_nettype none
module cmf_cell #(
  parameter int SAMPLE_W = 16,
  parameter int CELL_IDX = 0
) (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  cmf_pkg::ctl_t                                ctl_i,
  input  cmf_pkg::cfg_t                                cfg_i,
  input  wire logic signed [SAMPLE_W-1:0]              samp_re_i,
  input  wire logic signed [SAMPLE_W-1:0]              samp_im_i,
  output logic signed [SAMPLE_W-1:0]                   samp_re_o,
  output logic signed [SAMPLE_W-1:0]                   samp_im_o,
  output logic signed [SAMPLE_W+cmf_pkg::TAP_W:0]      term_re_o,
  output logic signed [SAMPLE_W+cmf_pkg::TAP_W:0]      term_im_o
);
  import cmf_pkg::*;

  localparam int PROD_W = SAMPLE_W + TAP_W;
  localparam int TERM_W = PROD_W + 1;
  localparam logic [IDX_W-2:0] CELL_SEL = (IDX_W-1)'(CELL_IDX);
  localparam logic [IDX_W-1:0] RE_IDX   = {CELL_SEL, 1'b0};
  localparam logic [IDX_W-1:0] IM_IDX   = {CELL_SEL, 1'b1};

  logic signed [TAP_W-1:0]    tap_re, tap_im;
  logic signed [SAMPLE_W-1:0] samp_re_q, samp_im_q, samp_re_d, samp_im_d;
  logic signed [PROD_W-1:0]   prod_rr_q, prod_ii_q, prod_ri_q, prod_ir_q;
  logic signed [TERM_W-1:0]   term_re_q, term_im_q;

  if (CELL_IDX < NUM_TAP_SETS) begin : g_taps
    logic signed [TAP_W-1:0] tap_re_q, tap_im_q;
    logic                    wr_ok;
    assign wr_ok = cfg_i.we && (cfg_i.idx < IDX_W'(NUM_REGS));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tap_re_q <= tap_reset(RE_IDX);
        tap_im_q <= tap_reset(IM_IDX);
      end else if (wr_ok && cfg_i.idx == RE_IDX) begin
        tap_re_q <= cfg_i.data;
      end else if (wr_ok && cfg_i.idx == IM_IDX) begin
        tap_im_q <= cfg_i.data;
      end
    end
    assign tap_re = tap_re_q;
    assign tap_im = tap_im_q;
  end else begin : g_no_taps
    assign tap_re = '0;
    assign tap_im = '0;
  end

  // frame start zeroes the history seen by every delayed cell
  assign samp_re_d = (ctl_i.clr && CELL_IDX != 0) ? '0 : samp_re_i;
  assign samp_im_d = (ctl_i.clr && CELL_IDX != 0) ? '0 : samp_im_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_re_q <= '0;
      samp_im_q <= '0;
    end else if (ctl_i.load) begin
      samp_re_q <= samp_re_d;
      samp_im_q <= samp_im_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.v1) begin
      prod_rr_q <= PROD_W'(tap_re) * PROD_W'(samp_re_q);
      prod_ii_q <= PROD_W'(tap_im) * PROD_W'(samp_im_q);
      prod_ri_q <= PROD_W'(tap_re) * PROD_W'(samp_im_q);
      prod_ir_q <= PROD_W'(tap_im) * PROD_W'(samp_re_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.v2) begin
      term_re_q <= TERM_W'(prod_rr_q) - TERM_W'(prod_ii_q);
      term_im_q <= TERM_W'(prod_ri_q) + TERM_W'(prod_ir_q);
    end
  end

  assign samp_re_o = samp_re_q;
  assign samp_im_o = samp_im_q;
  assign term_re_o = term_re_q;
  assign term_im_o = term_im_q;

endmodule
`default_nettype wire

@@ src/complex_multipath_fir_core.sv @@
// Top level of the complex multipath FIR core: cell row, sum, round and saturate.
//
// channel   direction  handshake                  payload
// in        sink       in_valid_i / in_ready_o    sample_real_i, sample_imag_i, frame_start_i
// out       source     out_valid_o / out_ready_i  out_real_o, out_imag_o, saturated_o
// cfg       sink       cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// One transaction per cycle sustained while the output is not held by out_ready_i.
// Stages: sample load, complex products, cell terms, tap sum, round/saturate.
// Whole pipeline advances together; it stalls only when the output is held by out_ready_i.
// Reset restores default taps and zero history; no clearing pass.
`default_nettype none
module complex_multipath_fir_core #(
  parameter int NUM_TAPS = cmf_pkg::DEF_NUM_TAPS,
  parameter int SAMPLE_W = cmf_pkg::DEF_SAMPLE_W
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0]       sample_real_i,
  input  wire logic signed [SAMPLE_W-1:0]       sample_imag_i,
  input  wire                                   frame_start_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [SAMPLE_W-1:0]            out_real_o,
  output logic signed [SAMPLE_W-1:0]            out_imag_o,
  output logic                                  saturated_o,
  input  wire                                   cfg_we_i,
  input  wire logic [cmf_pkg::IDX_W-1:0]        cfg_idx_i,
  input  wire logic [cmf_pkg::TAP_W-1:0]        cfg_data_i
);
  import cmf_pkg::*;

  localparam int TERM_W = SAMPLE_W + TAP_W + 1;
  localparam int ACC_W  = TERM_W + 2;
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(64'sd1 <<< (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(64'sd1 <<< (SAMPLE_W - 1)));

  ctl_t ctl;
  cfg_t cfg;
  logic adv, accept;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;

  logic signed [SAMPLE_W-1:0] samp_re [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] samp_im [NUM_TAPS];
  logic signed [TERM_W-1:0]   term_re [NUM_TAPS];
  logic signed [TERM_W-1:0]   term_im [NUM_TAPS];

  logic signed [ACC_W-1:0]    acc_re_d, acc_im_d, acc_re_q, acc_im_q;
  logic signed [ACC_W-1:0]    sh_re, sh_im;
  logic                       clip_re, clip_im;
  logic signed [SAMPLE_W-1:0] res_re, res_im;
  logic signed [SAMPLE_W-1:0] out_re_q, out_im_q;
  logic                       sat_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && adv;
  assign in_ready_o = adv;

  assign ctl.adv  = adv;
  assign ctl.load = accept;
  assign ctl.clr  = frame_start_i;
  assign ctl.v1   = v1_q;
  assign ctl.v2   = v2_q;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_cell
    logic signed [SAMPLE_W-1:0] src_re, src_im;
    if (g == 0) begin : g_head
      assign src_re = sample_real_i;
      assign src_im = sample_imag_i;
    end else begin : g_link
      assign src_re = samp_re[g-1];
      assign src_im = samp_im[g-1];
    end
    cmf_cell #(
      .SAMPLE_W (SAMPLE_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .cfg_i     (cfg),
      .samp_re_i (src_re),
      .samp_im_i (src_im),
      .samp_re_o (samp_re[g]),
      .samp_im_o (samp_im[g]),
      .term_re_o (term_re[g]),
      .term_im_o (term_im[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  always_comb begin
    acc_re_d = RND;
    acc_im_d = RND;
    for (int d = 0; d < NUM_TAPS; d++) begin
      acc_re_d = acc_re_d + ACC_W'(term_re[d]);
      acc_im_d = acc_im_d + ACC_W'(term_im[d]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  assign sh_re   = acc_re_q >>> FRAC_W;
  assign sh_im   = acc_im_q >>> FRAC_W;
  assign clip_re = (sh_re > SAT_HI) || (sh_re < SAT_LO);
  assign clip_im = (sh_im > SAT_HI) || (sh_im < SAT_LO);
  assign res_re  = (sh_re > SAT_HI) ? SAT_HI[SAMPLE_W-1:0] :
                   (sh_re < SAT_LO) ? SAT_LO[SAMPLE_W-1:0] : sh_re[SAMPLE_W-1:0];
  assign res_im  = (sh_im > SAT_HI) ? SAT_HI[SAMPLE_W-1:0] :
                   (sh_im < SAT_LO) ? SAT_LO[SAMPLE_W-1:0] : sh_im[SAMPLE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (adv && v4_q) begin
      out_re_q <= res_re;
      out_im_q <= res_im;
      sat_q    <= clip_re || clip_im;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_real_o  = out_re_q;
  assign out_imag_o  = out_im_q;
  assign saturated_o = sat_q;

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({v1_q, v2_q, v3_q, v4_q}) && $stable(samp_re[0]))
    else $error("pipeline moved during stall");

  a_sat_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      out_real_o == SAT_HI[SAMPLE_W-1:0] || out_real_o == SAT_LO[SAMPLE_W-1:0] ||
      out_imag_o == SAT_HI[SAMPLE_W-1:0] || out_imag_o == SAT_LO[SAMPLE_W-1:0])
    else $error("saturation flag without clipped value");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q && samp_re[0] == $past(sample_real_i))
    else $error("accepted transaction not loaded into first cell");

  if (NUM_TAPS > 1) begin : g_clr_chk
    a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
      accept && frame_start_i |=> samp_re[1] == '0 && samp_im[1] == '0)
      else $error("frame start did not clear history");
  end

endmodule
`default_nettype wire

@@ dv/fir_output_checker.sv @@
// Checker for the complex multipath FIR core: predicts every filtered sample and compares it.
`timescale 1ns / 100ps
module fir_output_checker #(
  parameter int SW   = cmf_pkg::DEF_SAMPLE_W,
  parameter int TAPS = cmf_pkg::DEF_NUM_TAPS
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  input  wire                              in_ready_i,
  input  wire logic signed [SW-1:0]        sample_real_i,
  input  wire logic signed [SW-1:0]        sample_imag_i,
  input  wire                              frame_start_i,
  input  wire                              out_valid_i,
  input  wire                              out_ready_i,
  input  wire logic signed [SW-1:0]        out_real_i,
  input  wire logic signed [SW-1:0]        out_imag_i,
  input  wire                              saturated_i,
  input  wire                              cfg_we_i,
  input  wire logic [cmf_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cmf_pkg::TAP_W-1:0]   cfg_data_i,
  output int                               errors_o,
  output int                               pending_o,
  output int                               checked_o,
  output int                               clipped_o
);

  localparam longint MAX_OUT  = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint MIN_OUT  = -MAX_OUT - 1;
  localparam longint HALF_LSB = longint'(1) <<< (cmf_pkg::FRAC_W - 1);

  typedef struct packed {
    logic [SW-1:0] re;
    logic [SW-1:0] im;
    logic          sat;
  } filt_out_t;

  logic signed [cmf_pkg::TAP_W-1:0] coef_re [cmf_pkg::NUM_TAP_SETS];
  logic signed [cmf_pkg::TAP_W-1:0] coef_im [cmf_pkg::NUM_TAP_SETS];
  logic signed [SW-1:0]             past_re [TAPS-1];
  logic signed [SW-1:0]             past_im [TAPS-1];
  filt_out_t                        expected_q [$];

  // Round half up, dropping FRAC_W fraction bits, then clip; MSB of the result flags a clip.
  function automatic logic [SW:0] round_clip(input longint acc);
    longint r;
    logic   clip;
    r    = (acc + HALF_LSB) >>> cmf_pkg::FRAC_W;
    clip = 1'b0;
    if (r > MAX_OUT) begin
      r    = MAX_OUT;
      clip = 1'b1;
    end else if (r < MIN_OUT) begin
      r    = MIN_OUT;
      clip = 1'b1;
    end
    return {clip, r[SW-1:0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic signed [SW-1:0] sr [TAPS];
    logic signed [SW-1:0] si [TAPS];
    longint               acc_re;
    longint               acc_im;
    logic [SW:0]          rr;
    logic [SW:0]          ri;
    filt_out_t            got;
    filt_out_t            want;
    if (!rst_ni) begin
      coef_re[0] = 16'sd13107;
      coef_im[0] = 16'sd0;
      coef_re[1] = 16'sd6554;
      coef_im[1] = 16'sd3277;
      coef_re[2] = 16'sd3277;
      coef_im[2] = -16'sd1638;
      for (int d = 0; d < TAPS - 1; d++) begin
        past_re[d] = '0;
        past_im[d] = '0;
      end
      expected_q.delete();
      errors_o  = 0;
      checked_o = 0;
      clipped_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cmf_pkg::REG_TAP0_RE: coef_re[0] = cfg_data_i;
          cmf_pkg::REG_TAP0_IM: coef_im[0] = cfg_data_i;
          cmf_pkg::REG_TAP1_RE: coef_re[1] = cfg_data_i;
          cmf_pkg::REG_TAP1_IM: coef_im[1] = cfg_data_i;
          cmf_pkg::REG_TAP2_RE: coef_re[2] = cfg_data_i;
          cmf_pkg::REG_TAP2_IM: coef_im[2] = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        checked_o++;
        got = '{re: out_real_i, im: out_imag_i, sat: saturated_i};
        if (expected_q.size() == 0) begin
          $error("output transaction with nothing expected: real %0d imag %0d",
                 out_real_i, out_imag_i);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.re !== want.re) begin
            $error("out_real: expected %0d, got %0d", $signed(want.re), $signed(got.re));
            errors_o++;
          end
          if (got.im !== want.im) begin
            $error("out_imag: expected %0d, got %0d", $signed(want.im), $signed(got.im));
            errors_o++;
          end
          if (got.sat !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, got.sat);
            errors_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        // frame start: older history reads as zero
        sr[0] = sample_real_i;
        si[0] = sample_imag_i;
        for (int d = 1; d < TAPS; d++) begin
          sr[d] = frame_start_i ? '0 : past_re[d-1];
          si[d] = frame_start_i ? '0 : past_im[d-1];
        end
        acc_re = 0;
        acc_im = 0;
        for (int d = 0; d < TAPS; d++) begin
          acc_re += longint'(coef_re[d]) * longint'(sr[d])
                  - longint'(coef_im[d]) * longint'(si[d]);
          acc_im += longint'(coef_re[d]) * longint'(si[d])
                  + longint'(coef_im[d]) * longint'(sr[d]);
        end
        rr = round_clip(acc_re);
        ri = round_clip(acc_im);
        want = '{re: rr[SW-1:0], im: ri[SW-1:0], sat: rr[SW] | ri[SW]};
        if (want.sat) clipped_o++;
        expected_q.push_back(want);
        for (int d = TAPS - 2; d > 0; d--) begin
          past_re[d] = sr[d];
          past_im[d] = si[d];
        end
        past_re[0] = sample_real_i;
        past_im[0] = sample_imag_i;
      end

      pending_o = expected_q.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
// Top of the FIR core testbench: clock, reset, tap settings, sample and ready stimulus, verdict.
`timescale 1ns / 100ps
module testbench;

  localparam int SW           = cmf_pkg::DEF_SAMPLE_W;
  localparam int LATENCY      = 5;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 120;
  localparam int ITEMS_PER_PH = 90;
  localparam int NUM_PHASES   = 12;

  localparam logic [cmf_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [cmf_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic signed [SW-1:0]          sample_re    = '0;
  logic signed [SW-1:0]          sample_im    = '0;
  logic                          frame_start  = 1'b0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic signed [SW-1:0]          out_re;
  logic signed [SW-1:0]          out_im;
  logic                          saturated;
  logic                          cfg_we       = 1'b0;
  logic [cmf_pkg::IDX_W-1:0]     cfg_idx      = '0;
  logic [cmf_pkg::TAP_W-1:0]     cfg_data     = '0;

  int  errors;
  int  pending;
  int  checked;
  int  clipped;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  quiet_cycles   = 0;
  int  tap_settings   = 1;
  bit  hold_req       = 1'b0;

  always #2 clk = ~clk;

  complex_multipath_fir_core u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_real_i (sample_re),
    .sample_imag_i (sample_im),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_real_o    (out_re),
    .out_imag_o    (out_im),
    .saturated_o   (saturated),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  fir_output_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .sample_real_i (sample_re),
    .sample_imag_i (sample_im),
    .frame_start_i (frame_start),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_real_i    (out_re),
    .out_imag_i    (out_im),
    .saturated_i   (saturated),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .errors_o      (errors),
    .pending_o     (pending),
    .checked_o     (checked),
    .clipped_o     (clipped)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
      end
    end
  end

  function automatic logic signed [SW-1:0] pick_sample();
    logic signed [SW-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       v = 16'sh7fff;
          1:       v = 16'sh8000;
          2:       v = 16'sh0000;
          3:       v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      1, 2: begin
        v = SW'($urandom_range(511));
        v = v - 16'sd256;
      end
      default: v = SW'($urandom);
    endcase
    return v;
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 53; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      IDLE_BOTH: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_sample(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im,
                             input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample_re   <= re;
    sample_im   <= im;
    frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [cmf_pkg::IDX_W-1:0] idx,
                           input logic [cmf_pkg::TAP_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic write_taps(input logic [15:0] t0r, input logic [15:0] t0i,
                            input logic [15:0] t1r, input logic [15:0] t1i,
                            input logic [15:0] t2r, input logic [15:0] t2i);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(cmf_pkg::REG_TAP0_RE, t0r);
    write_reg(cmf_pkg::REG_TAP0_IM, t0i);
    write_reg(cmf_pkg::REG_TAP1_RE, t1r);
    write_reg(cmf_pkg::REG_TAP1_IM, t1i);
    write_reg(cmf_pkg::REG_TAP2_RE, t2r);
    write_reg(cmf_pkg::REG_TAP2_IM, t2i);
    write_reg(REG_SPARE_HI, 16'($urandom));
    cfg_we <= 1'b0;
    @(negedge clk);
    tap_settings++;
  endtask

  initial begin : stimulus
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default taps: frame start right after reset, full scale, sign mixes
    set_idling(IDLE_NONE);
    send_sample(16'sh0000, 16'sh0000, 1'b1);
    repeat (3) send_sample(16'sh7fff, 16'sh7fff, 1'b0);
    repeat (3) send_sample(16'sh8000, 16'sh8000, 1'b0);
    send_sample(16'sh8000, 16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 16'sh8000, 1'b1);
    send_sample(16'sd1, -16'sd1, 1'b0);
    send_sample(-16'sd1, 16'sd1, 1'b0);
    send_sample(16'sh5555, 16'shaaaa, 1'b0);
    send_sample(16'shaaaa, 16'sh5555, 1'b0);
    drain();

    // unit-LSB tap makes the rounding ties visible
    write_taps(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'sd8192, -16'sd8192, 1'b1);
    send_sample(-16'sd8192, 16'sd8192, 1'b0);
    send_sample(16'sd24576, -16'sd24576, 1'b0);
    send_sample(-16'sd24576, 16'sd24576, 1'b0);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_taps(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        1: write_taps(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        2: write_taps(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        3: write_taps(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        4: write_taps(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        default: write_taps(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      set_idling(idle_mode_e'(ph % 4));
      if (ph == 6) hold_req = 1'b1;
      repeat (ITEMS_PER_PH) send_sample(pick_sample(), pick_sample(), $urandom_range(19) == 0);
      drain();
    end

    $display("Covered %0d filtered samples over %0d tap settings, %0d of them clipped.",
             checked, tap_settings, clipped);
    $display("Idling mixes: none, sender gaps, output stalls, both; one long output hold-off.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
